[src/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// Shared widths, register indexes and types of the RMS decibel level meter.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SAMPLE_W        = 16;  // width of the sample field
  localparam int SAMPLE_BITS_DEF = 16;  // sample bits taken as two's complement
  localparam int ACC_W           = 46;  // sum of squares, wraps
  localparam int LEN_W           = 16;
  localparam int GAIN_W          = 20;
  localparam int LEVEL_W         = 8;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 20;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST = 16'd8000;
  localparam logic [GAIN_W-1:0] GAIN_K_RST       = 20'd29659;

  // 10*log10(2) in Q24
  localparam logic signed [26:0] TEN_LOG10_2_Q24 = 27'sd50504453;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 8'sh80;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 8'sh7f;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_K       = 1'b1;

  // one finished block handed from the front to the back
  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic [LEN_W-1:0] len;
  } rms_blk_t;

  // queue status seen by the front
  typedef struct packed {
    logic       valid;
    logic [1:0] count;
  } rms_qstat_t;

endpackage

[src/rms_sample_if.sv]
// ----------------------------------------------------------------------------
// rms_sample_if
// Audio sample channel: valid/ready handshake with one sample per word.
// ----------------------------------------------------------------------------
interface rms_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [rms_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[src/rms_level_if.sv]
// ----------------------------------------------------------------------------
// rms_level_if
// Level result channel: valid/ready handshake, level in dB and silent flag.
// ----------------------------------------------------------------------------
interface rms_level_if;
  logic                               valid;
  logic                               ready;
  logic signed [rms_pkg::LEVEL_W-1:0] level_db;
  logic                               silent;

  modport source (output valid, output level_db, output silent, input ready);
  modport sink   (input valid, input level_db, input silent, output ready);
endinterface

[src/rms_cfg_if.sv]
// ----------------------------------------------------------------------------
// rms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rms_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rms_pkg::CFG_IDX_W-1:0]     index;
  logic [rms_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/rms_front.sv]
// ----------------------------------------------------------------------------
// rms_front
// Squares incoming samples, sums them and closes a block at the set length.
// ----------------------------------------------------------------------------
module rms_front #(
  parameter int SAMPLE_BITS = rms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  rms_sample_if.sink                 smp,
  input  logic [rms_pkg::LEN_W-1:0]  block_length,
  input  rms_pkg::rms_qstat_t        qstat,
  output logic                       push,
  output rms_pkg::rms_blk_t          push_blk
);
  import rms_pkg::*;

  localparam int EXT_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS;

  logic [EXT_W-1:0]              ext;
  logic signed [SAMPLE_BITS-1:0] sv;
  logic signed [SQ_W-1:0]        sq_full;
  logic [LEN_W-1:0]              len_eff;
  logic [LEN_W-1:0]              count_inc;
  logic                          last;
  logic                          accept;
  logic [ACC_W-1:0]              total;

  // square stage
  logic                          sq_valid;
  logic                          sq_last;
  logic [ACC_W-1:0]              sq;
  logic [LEN_W-1:0]              sq_len;

  logic [ACC_W-1:0]              acc;
  logic [LEN_W-1:0]              count;

  assign ext     = EXT_W'($unsigned(smp.sample));
  assign sv      = signed'(ext[SAMPLE_BITS-1:0]);
  assign sq_full = sv * sv;

  assign len_eff   = (block_length == '0) ? LEN_W'(1) : block_length;
  assign count_inc = count + LEN_W'(1);
  assign last      = (count_inc >= len_eff);

  // any word may close a block, so keep a queue slot free for it
  assign smp.ready = (qstat.count == 2'd0) || (qstat.count == 2'd1 && !(sq_valid && sq_last));
  assign accept    = smp.valid && smp.ready;

  assign total         = acc + sq;
  assign push          = sq_valid && sq_last;
  assign push_blk.sum  = total;
  assign push_blk.len  = sq_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      sq_last  <= 1'b0;
      acc      <= '0;
      count    <= '0;
    end else begin
      sq_valid <= accept;
      if (accept) begin
        sq      <= ACC_W'($unsigned(sq_full));
        sq_last <= last;
        sq_len  <= len_eff;
        count   <= last ? '0 : count_inc;
      end
      if (sq_valid) begin
        acc <= sq_last ? '0 : total;
      end
    end
  end

endmodule

[src/rms_queue.sv]
// ----------------------------------------------------------------------------
// rms_queue
// Two-entry queue of finished block sums between the front and the back.
// ----------------------------------------------------------------------------
module rms_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rms_pkg::rms_blk_t    push_blk,
  input  logic                 pop,
  output rms_pkg::rms_qstat_t  qstat,
  output rms_pkg::rms_blk_t    head
);
  import rms_pkg::*;

  rms_blk_t   entries [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign do_pop      = pop && (count != 2'd0);
  assign qstat.valid = (count != 2'd0);
  assign qstat.count = count;
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_blk;
        wr_ptr          <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

[src/rms_back.sv]
// ----------------------------------------------------------------------------
// rms_back
// Sequencer: mean by restoring division, log2 by normalize and squaring,
// scale to decibels, saturate and hold the result for the output channel.
// ----------------------------------------------------------------------------
module rms_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rms_pkg::rms_qstat_t         qstat,
  input  rms_pkg::rms_blk_t           head,
  output logic                        pop,
  input  logic [rms_pkg::GAIN_W-1:0]  gain_k,
  rms_level_if.source                 lvl
);
  import rms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CHK, S_NORM, S_FRAC, S_ADD, S_MUL, S_SAT, S_DONE
  } state_t;

  state_t               state;
  logic [LEN_W-1:0]     rem;
  logic [ACC_W-1:0]     quo;     // quotient, then the word being normalized
  logic [LEN_W-1:0]     div_len;
  logic [5:0]           cnt;
  logic [5:0]           expo;
  logic [30:0]          m;
  logic [15:0]          frac;
  logic signed [23:0]   t;
  logic                 on_gain;
  logic signed [50:0]   p;
  logic [7:0]           res_lvl;
  logic                 res_silent;

  logic [LEN_W:0]       rem_sh;
  logic                 q_bit;
  logic [61:0]          sqr;
  logic [31:0]          mm;
  logic                 p_neg;
  logic [50:0]          p_mag;
  logic [10:0]          p_int;

  assign pop    = (state == S_IDLE) && qstat.valid;
  assign rem_sh = {rem, quo[ACC_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_len});
  assign sqr    = {31'd0, m} * {31'd0, m};
  assign mm     = sqr[61:30];
  assign p_neg  = p[50];
  assign p_mag  = p_neg ? 51'(-p) : 51'(p);
  assign p_int  = p_mag[50:40];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl.valid <= 1'b0;
    end else begin
      if (lvl.valid && lvl.ready) begin
        lvl.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (qstat.valid) begin
            rem     <= '0;
            quo     <= head.sum;
            div_len <= head.len;
            cnt     <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= q_bit ? LEN_W'(rem_sh - {1'b0, div_len}) : rem_sh[LEN_W-1:0];
          quo <= {quo[ACC_W-2:0], q_bit};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(ACC_W - 1)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (quo == '0) begin
            res_lvl    <= LEVEL_MIN;
            res_silent <= 1'b1;
            state      <= S_DONE;
          end else if (gain_k == '0) begin
            res_lvl    <= LEVEL_MIN;
            res_silent <= 1'b0;
            state      <= S_DONE;
          end else begin
            expo    <= 6'(ACC_W - 1);
            on_gain <= 1'b0;
            t       <= -24'sd2097152;  // -32 in Q16
            state   <= S_NORM;
          end
        end
        S_NORM: begin
          // one bit a cycle until the leading one sits at the top
          if (quo[ACC_W-1]) begin
            m     <= quo[ACC_W-1:ACC_W-31];
            frac  <= '0;
            cnt   <= '0;
            state <= S_FRAC;
          end else begin
            quo  <= {quo[ACC_W-2:0], 1'b0};
            expo <= expo - 6'd1;
          end
        end
        S_FRAC: begin
          frac <= {frac[14:0], mm[31]};
          m    <= mm[31] ? mm[31:1] : mm[30:0];
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd15) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (!on_gain) begin
            t       <= t + signed'(24'({expo, frac}));
            quo     <= ACC_W'(gain_k);
            expo    <= 6'(ACC_W - 1);
            on_gain <= 1'b1;
            state   <= S_NORM;
          end else begin
            t     <= t + signed'(24'({expo, frac, 1'b0}));
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p     <= 51'(t * TEN_LOG10_2_Q24);
          state <= S_SAT;
        end
        S_SAT: begin
          res_silent <= 1'b0;
          if (!p_neg) begin
            res_lvl <= (p_int > 11'd127) ? LEVEL_MAX : p_int[7:0];
          end else begin
            res_lvl <= (p_int > 11'd128) ? LEVEL_MIN : 8'(-p_int);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!lvl.valid) begin
            lvl.valid    <= 1'b1;
            lvl.level_db <= res_lvl;
            lvl.silent   <= res_silent;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/block_rms_decibel_level_meter.sv]
// ----------------------------------------------------------------------------
// block_rms_decibel_level_meter
// Block RMS sound level meter: sums squared samples over a block and reports
// 20*log10(sqrt(mean)*K) in whole decibels.
//
//   channel  dir  handshake     payload
//   smp      in   valid/ready   sample (s16)
//   lvl      out  valid/ready   level_db (s8), silent
//   cfg      in   valid/ready   index (0 block_length, 1 gain_k), data (u20)
//
// Samples are taken one per cycle unless the input stalls; the square and
// the sum are one stage each. A finished block waits in a two-entry queue;
// the back end runs 46 division steps, then, unless silent or at zero gain,
// up to 45 normalize shifts and 16 squaring steps per logarithm, twice.
// Input stalls when both queue slots are taken, or one is taken while a
// closing word sits in the square stage. The back end holds its result until
// the previous level word is taken. Reset is synchronous, no clearing pass.
// ----------------------------------------------------------------------------
module block_rms_decibel_level_meter #(
  parameter int SAMPLE_BITS = rms_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rms_sample_if.sink  smp,
  rms_level_if.source lvl,
  rms_cfg_if.sink     cfg
);
  import rms_pkg::*;

  logic [LEN_W-1:0]  block_length;
  logic [GAIN_W-1:0] gain_k;
  logic              push;
  logic              pop;
  rms_blk_t          push_blk;
  rms_blk_t          head;
  rms_qstat_t        qstat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LENGTH_RST;
      gain_k       <= GAIN_K_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BLOCK_LENGTH: block_length <= cfg.data[LEN_W-1:0];
        REG_GAIN_K:       gain_k       <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  rms_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .smp          (smp),
    .block_length (block_length),
    .qstat        (qstat),
    .push         (push),
    .push_blk     (push_blk)
  );

  rms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_blk (push_blk),
    .pop      (pop),
    .qstat    (qstat),
    .head     (head)
  );

  rms_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop),
    .gain_k (gain_k),
    .lvl    (lvl)
  );

endmodule

[src/rms_chk.sv]
// ----------------------------------------------------------------------------
// rms_chk
// Port-level checks on the level output of the meter, bound to the top.
// ----------------------------------------------------------------------------
module rms_chk (
  input logic         clk,
  input logic         rst,
  rms_level_if.source lvl
);
  import rms_pkg::*;

  // a silent block always reports the floor level
  a_silent_floor: assert property (@(posedge clk) disable iff (rst)
    lvl.valid && lvl.silent |-> lvl.level_db == LEVEL_MIN)
    else $error("silent word without floor level");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    lvl.valid && !lvl.ready |=> lvl.valid && $stable(lvl.level_db) && $stable(lvl.silent))
    else $error("level word changed while stalled");

  // results are far apart: none directly after a delivered one
  a_gap: assert property (@(posedge clk) disable iff (rst)
    lvl.valid && lvl.ready |=> !lvl.valid)
    else $error("back-to-back level words");

endmodule

bind block_rms_decibel_level_meter rms_chk u_chk (
  .clk (clk),
  .rst (rst),
  .lvl (lvl)
);

[bench/tb_block_rms_decibel_level_meter.sv]
// ----------------------------------------------------------------------------
// tb_block_rms_decibel_level_meter
// Self-checking bench for the block RMS level meter. A local fixed-point
// model of the mean-square and log2 datapath predicts every level word.
// Covered: reset register values, zero and unit block length, gain
// extremes, floor of the mean, block length changed mid-block, a long
// block at full scale, then random settings with random sample mixes under
// bursty input and a stalling level sink.
// ----------------------------------------------------------------------------
module tb_block_rms_decibel_level_meter;
  import rms_pkg::*;

  localparam int          SMP_BITS     = SAMPLE_BITS_DEF;
  localparam int          SETTLE_CYC   = 8;    // square and sum stages
  localparam int          DRAIN_CYC    = 400;  // two queued blocks in the back end
  localparam int          RANDOM_ITEMS = 1150;
  localparam longint      CYCLE_LIMIT  = 3000000;
  localparam longint      DB_PER_OCT   = 64'sd50504453;  // 10*log10(2), Q24

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level_db;
    logic                      silent;
  } level_word_t;

  logic clk = 1'b0;
  logic rst;

  rms_sample_if smp ();
  rms_level_if  lvl ();
  rms_cfg_if    cfg ();

  block_rms_decibel_level_meter #(.SAMPLE_BITS(SMP_BITS)) DUT (
    .clk (clk),
    .rst (rst),
    .smp (smp),
    .lvl (lvl),
    .cfg (cfg)
  );

  always #2 clk = ~clk;

  // local copy of the meter state
  logic [ACC_W-1:0]  sq_sum;
  logic [LEN_W-1:0]  sq_count;
  logic [LEN_W-1:0]  blk_len;
  logic [GAIN_W-1:0] gain;

  level_word_t    pending_levels[$];
  int             mismatches = 0;
  longint unsigned cycles = 0;
  int             burst_left = 0;
  bit             bulk_flow = 1'b0;
  int             hold_left = 0;
  level_word_t    want;

  // log2 in Q16 by normalize and repeated squaring
  function automatic longint log2_q16(input longint unsigned v);
    int              msb;
    int              b;
    longint unsigned m;
    longint          frac;
    msb = 0;
    for (b = 0; b < 64; b++)
      if (v[b]) msb = b;
    if (msb > 30) m = v >> (msb - 30);
    else          m = v << (30 - msb);
    frac = 0;
    repeat (16) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(msb) * 65536 + frac;
  endfunction

  function automatic level_word_t predict_level(input logic [ACC_W-1:0] sum,
                                                input logic [LEN_W-1:0] len);
    longint unsigned mean_sq;
    longint          tq;
    longint          prod;
    longint          db;
    level_word_t     w;
    mean_sq  = 64'(sum) / 64'(len);
    w.silent = 1'b0;
    if (mean_sq == 0) begin
      w.level_db = LEVEL_MIN;
      w.silent   = 1'b1;
    end else if (gain == '0) begin
      w.level_db = LEVEL_MIN;
    end else begin
      tq   = log2_q16(mean_sq) + 2 * log2_q16(64'(gain)) - 32 * 65536;
      prod = tq * DB_PER_OCT;
      // Q40 product, truncate toward zero
      if (prod < 0) db = -((-prod) >> 40);
      else          db = prod >> 40;
      if (db > 127)  db = 127;
      if (db < -128) db = -128;
      w.level_db = db[LEVEL_W-1:0];
    end
    return w;
  endfunction

  function automatic void account_sample(input logic signed [SAMPLE_W-1:0] s);
    longint          v;
    logic [LEN_W-1:0] eff_len;
    v = longint'($unsigned(s)) & ((64'sd1 <<< SMP_BITS) - 1);
    if (v[SMP_BITS-1]) v = v - (64'sd1 <<< SMP_BITS);
    sq_sum   = sq_sum + ACC_W'(v * v);
    sq_count = sq_count + 1'b1;
    eff_len  = (blk_len == '0) ? LEN_W'(1) : blk_len;
    if (sq_count >= eff_len) begin
      pending_levels.push_back(predict_level(sq_sum, eff_len));
      sq_sum   = '0;
      sq_count = '0;
    end
  endfunction

  // level sink with its own stall pattern; quiet windows give full-rate stretches
  always @(posedge clk) begin
    if (rst) begin
      lvl.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      lvl.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      lvl.ready <= 1'b1;
      if (cycles[11:10] != 2'd0) begin
        case ($urandom_range(0, 63))
          0, 1, 2, 3, 4, 5, 6, 7: hold_left <= $urandom_range(1, 5);
          8:                      hold_left <= $urandom_range(40, 300);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && lvl.valid && lvl.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected level word: expected none, actual level_db=%0d silent=%0b",
                 $time, $signed(lvl.level_db), lvl.silent);
        mismatches++;
      end else begin
        want = pending_levels.pop_front();
        if (lvl.level_db !== want.level_db) begin
          $display("%0t: level_db expected %0d actual %0d", $time,
                   $signed(want.level_db), $signed(lvl.level_db));
          mismatches++;
        end
        if (lvl.silent !== want.silent) begin
          $display("%0t: silent expected %0b actual %0b", $time, want.silent, lvl.silent);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("block_rms_decibel_level_meter: mismatch");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      if (bulk_flow) begin
        gap        = $urandom_range(0, 2);
        burst_left = $urandom_range(64, 512);
      end else begin
        gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(0, 3);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                 : $urandom_range(1, 24);
      end
      if (gap != 0) begin
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    smp.valid  <= 1'b1;
    smp.sample <= s;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    burst_left--;
    account_sample(s);
  endtask

  // drop valid and let every expected word and the front pipeline drain
  task automatic wait_idle();
    smp.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_BLOCK_LENGTH: blk_len = data[LEN_W-1:0];
      REG_GAIN_K:       gain    = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int mix);
    case (mix)
      0: return '0;
      1: return SAMPLE_W'($urandom_range(0, 2) - 1);
      2: return SAMPLE_W'($urandom);
      3: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return -16'sd1;
          3:       return 16'sd1;
          default: return '0;
        endcase
      end
      4: return SAMPLE_W'(int'($urandom_range(0, 510)) - 255);
      default: return ($urandom_range(0, 3) == 0) ? '0 : SAMPLE_W'($urandom);
    endcase
  endfunction

  // reset length keeps the block open; a shorter length then closes it
  // at the reset gain
  task automatic test_reset_registers();
    repeat (100) send_sample(pick_sample(2));
    write_reg(REG_BLOCK_LENGTH, 20'd50);
    send_sample(pick_sample(2));
  endtask

  // zero length behaves as one; upper data bits are dropped
  task automatic test_unit_length();
    write_reg(REG_BLOCK_LENGTH, 20'hF0000);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
  endtask

  // zero gain gives the floor level without silent; max and min gain
  task automatic test_gain_extremes();
    write_reg(REG_BLOCK_LENGTH, 20'h00001);
    write_reg(REG_GAIN_K, 20'h00000);
    send_sample(16'sd100);
    send_sample(16'sd0);
    write_reg(REG_GAIN_K, 20'hFFFFF);
    send_sample(16'sh8000);
    send_sample(16'sd1);
    write_reg(REG_GAIN_K, 20'h00001);
    send_sample(16'sd1);
    send_sample(16'sh8000);
  endtask

  // mean is floored, so a tiny sum over two samples reads as silent
  task automatic test_mean_floor();
    write_reg(REG_GAIN_K, GAIN_K_RST);
    write_reg(REG_BLOCK_LENGTH, 20'd2);
    send_sample(16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd3);
    send_sample(16'sd0);
  endtask

  task automatic test_length_change_mid_block();
    write_reg(REG_BLOCK_LENGTH, 20'd6);
    repeat (4) send_sample(pick_sample(2));
    write_reg(REG_BLOCK_LENGTH, 20'd3);   // already past the new length
    send_sample(pick_sample(2));
    write_reg(REG_BLOCK_LENGTH, 20'd6);
    repeat (2) send_sample(pick_sample(4));
    write_reg(REG_BLOCK_LENGTH, 20'd4);
    repeat (2) send_sample(pick_sample(4));
    write_reg(REG_BLOCK_LENGTH, 20'd2);
    send_sample(pick_sample(2));
    write_reg(REG_BLOCK_LENGTH, 20'd3);   // raised mid-block
    repeat (2) send_sample(pick_sample(2));
  endtask

  // full-scale samples over a long block: a large sum through the divider
  task automatic test_full_scale_block();
    write_reg(REG_GAIN_K, 20'hFFFFF);
    write_reg(REG_BLOCK_LENGTH, 20'd300);
    bulk_flow = 1'b1;
    repeat (300) send_sample(16'sh8000);
    bulk_flow = 1'b0;
  endtask

  task automatic test_random_blocks();
    int               sent;
    int               n;
    int               mix;
    logic [LEN_W-1:0] len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) != 0) begin
        case ($urandom_range(0, 9))
          0:       len = '0;
          1:       len = LEN_W'(1);
          2:       len = LEN_W'($urandom_range(200, 700));
          default: len = LEN_W'($urandom_range(2, 40));
        endcase
        write_reg(REG_BLOCK_LENGTH, {4'($urandom_range(0, 15)), len});
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(REG_GAIN_K, 20'h00000);
          1:       write_reg(REG_GAIN_K, 20'h00001);
          2:       write_reg(REG_GAIN_K, 20'hFFFFF);
          3:       write_reg(REG_GAIN_K, GAIN_K_RST);
          default: write_reg(REG_GAIN_K, GAIN_W'($urandom));
        endcase
      end
      len = (blk_len == '0) ? LEN_W'(1) : blk_len;
      n   = $urandom_range(1, 3 * int'(len) + 2);
      if (n > 400) n = 400;
      mix = $urandom_range(0, 5);
      repeat (n) send_sample(pick_sample(mix));
      sent += n;
    end
  endtask

  initial begin
    rst        = 1'b1;
    smp.valid  = 1'b0;
    smp.sample = '0;
    cfg.valid  = 1'b0;
    cfg.index  = REG_BLOCK_LENGTH;
    cfg.data   = '0;
    lvl.ready  = 1'b0;
    sq_sum     = '0;
    sq_count   = '0;
    blk_len    = BLOCK_LENGTH_RST;
    gain       = GAIN_K_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_registers();
    test_unit_length();
    test_gain_extremes();
    test_mean_floor();
    test_length_change_mid_block();
    test_full_scale_block();
    test_random_blocks();

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("block_rms_decibel_level_meter: match");
    end else begin
      $display("block_rms_decibel_level_meter: mismatch");
    end
    $finish;
  end

endmodule
